// File: sv/vgfp_pkg.sv
// Shared types, character codes and register map for the VCF genotype field parser.
// Used by vgfp_prob_step, vgfp_parser and vcf_genotype_field_parser; no dependencies.
`timescale 1ns / 1ps

package vgfp_pkg;

    localparam int MAX_SUBFIELDS = 16;
    localparam int FRAC_DIGITS   = 4;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;
    localparam int MINP_W = 14;
    localparam int PROB_SCALE = 10000;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [1:0] REG_GT_FIELD   = 2'd0;
    localparam logic [1:0] REG_GP_FIELD   = 2'd1;
    localparam logic [1:0] REG_GP_PRESENT = 2'd2;
    localparam logic [1:0] REG_MIN_PROB   = 2'd3;

    localparam logic [1:0] GENO_MISSING = 2'd3;
    localparam logic [1:0] PROB_TRIPLE  = 2'd3;

    typedef struct packed {
        logic [3:0]        gt_field;
        logic [3:0]        gp_field;
        logic              gp_present;
        logic [MINP_W-1:0] min_prob;
    } cfg_t;

    typedef struct packed {
        logic [1:0] count;
        logic       any_ok;
        logic       perr;
        logic       in_frac;
        logic       has_digit;
    } prob_flags_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] genotype;
        logic       low_quality;
    } result_t;

    function automatic longint unsigned pow_ten(input int n);
        longint unsigned r;
        r = 1;
        for (int i = 0; i < 12; i++) begin
            if (i < n) begin
                r = r * 10;
            end
        end
        return r;
    endfunction

    function automatic int acc_width(input int f);
        return $clog2(2 * pow_ten(f) + 1);
    endfunction

    function automatic int fd_width(input int f);
        return $clog2(f + 1);
    endfunction

endpackage

// File: sv/vcf_genotype_field_parser.sv
// VCF genotype field parser top level: APB register file, input word register,
// parser and result register. Depends on vgfp_pkg and vgfp_parser.
`timescale 1ns / 1ps
//
// Feed the raw bytes of a line's sample columns on the s_ stream, one byte per
// word. Tab, space, CR or LF ends a sample; each non-empty sample yields one
// result word on the m_ stream holding the alternate allele dosage (3 when
// missing or rejected) and a low-quality flag. Other bytes yield no word.
// Program gt_field, gp_field, gp_present and min_prob over APB at byte
// addresses 0, 4, 8, 12 while the stream is idle; reads return the values.
// A byte accepted into the input word register is parsed when the parser steps,
// and its result word, if any, is loaded into the result register at that step.
// The stream takes one byte per cycle while the receiver is not stalling.
// The input word register and the result register decouple the two sides:
// a byte is taken while a finished result waits, and a stalled receiver
// stops the stream only when both registers are full.
// Reset clears the configuration, the parser state and both valid flags.
//

module vcf_genotype_field_parser #(
    parameter int MAX_SUBFIELDS = vgfp_pkg::MAX_SUBFIELDS,
    parameter int FRAC_DIGITS   = vgfp_pkg::FRAC_DIGITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vgfp_pkg::CFG_AW-1:0] paddr,
    input  logic [vgfp_pkg::CFG_DW-1:0] pwdata,
    output logic [vgfp_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] ch
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // [1:0] genotype, [2] low_quality
);

    vgfp_pkg::cfg_t    cfg_reg;
    logic              in_valid_reg;
    logic [7:0]        ch_reg;
    logic              out_valid_reg;
    logic [1:0]        geno_reg;
    logic              lowq_reg;
    logic              step;
    logic              cfg_wr;
    vgfp_pkg::result_t res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            vgfp_pkg::REG_GT_FIELD:   prdata = vgfp_pkg::CFG_DW'(cfg_reg.gt_field);
            vgfp_pkg::REG_GP_FIELD:   prdata = vgfp_pkg::CFG_DW'(cfg_reg.gp_field);
            vgfp_pkg::REG_GP_PRESENT: prdata = vgfp_pkg::CFG_DW'(cfg_reg.gp_present);
            vgfp_pkg::REG_MIN_PROB:   prdata = vgfp_pkg::CFG_DW'(cfg_reg.min_prob);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                vgfp_pkg::REG_GT_FIELD:   cfg_reg.gt_field   <= pwdata[3:0];
                vgfp_pkg::REG_GP_FIELD:   cfg_reg.gp_field   <= pwdata[3:0];
                vgfp_pkg::REG_GP_PRESENT: cfg_reg.gp_present <= pwdata[0];
                vgfp_pkg::REG_MIN_PROB:
                    cfg_reg.min_prob <= pwdata[vgfp_pkg::MINP_W-1:0];
                default: ;
            endcase
        end
    end

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            ch_reg <= s_tdata;
        end
    end

    vgfp_parser #(
        .MAX_SUBFIELDS (MAX_SUBFIELDS),
        .FRAC_DIGITS   (FRAC_DIGITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (step),
        .ch      (ch_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= res.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res.valid) begin
            geno_reg <= res.genotype;
            lowq_reg <= res.low_quality;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, lowq_reg, geno_reg};

endmodule

// File: sv/vgfp_prob_step.sv
// Next-value logic for one genotype-probability value: digit accumulation in fixed
// point, value finish, threshold compare. Depends on vgfp_pkg.
`timescale 1ns / 1ps

module vgfp_prob_step #(
    parameter int FRAC_DIGITS = vgfp_pkg::FRAC_DIGITS
) (
    input  logic [7:0]                                   ch,
    input  logic                                         do_char,
    input  logic                                         do_finish,
    input  logic [vgfp_pkg::MINP_W-1:0]                  min_prob,
    input  logic [vgfp_pkg::acc_width(FRAC_DIGITS)-1:0]  acc,
    input  logic [vgfp_pkg::fd_width(FRAC_DIGITS)-1:0]   fds,
    input  vgfp_pkg::prob_flags_t                        flags,
    output logic [vgfp_pkg::acc_width(FRAC_DIGITS)-1:0]  acc_next,
    output logic [vgfp_pkg::fd_width(FRAC_DIGITS)-1:0]   fds_next,
    output vgfp_pkg::prob_flags_t                        flags_next
);

    localparam int ACC_W = vgfp_pkg::acc_width(FRAC_DIGITS);
    localparam int FD_W  = vgfp_pkg::fd_width(FRAC_DIGITS);
    localparam int SUM_W = ACC_W + 4;
    localparam int CMP_W = ACC_W + vgfp_pkg::MINP_W;
    localparam longint unsigned POW_F = vgfp_pkg::pow_ten(FRAC_DIGITS);
    localparam longint unsigned CAP   = 2 * POW_F;

    logic [ACC_W-1:0] wtab [2**FD_W];

    for (genvar i = 0; i < 2**FD_W; i++) begin : g_wtab
        if (i < FRAC_DIGITS) begin : g_used
            assign wtab[i] = ACC_W'(vgfp_pkg::pow_ten(FRAC_DIGITS - 1 - i));
        end else begin : g_unused
            assign wtab[i] = '0;
        end
    end

    logic              is_digit;
    logic [3:0]        digit;
    logic [SUM_W-1:0]  int_sum;
    logic [SUM_W-1:0]  frac_sum;
    logic [ACC_W-1:0]  int_sat;
    logic [ACC_W-1:0]  frac_sat;
    logic [CMP_W-1:0]  scaled;
    logic [CMP_W-1:0]  thresh;
    logic [1:0]        fin_count;
    logic              fin_any;
    logic              fin_perr;

    assign is_digit = (ch >= vgfp_pkg::CH_ZERO) && (ch <= vgfp_pkg::CH_NINE);
    assign digit    = ch[3:0];
    assign int_sum  = SUM_W'(acc) * SUM_W'(10) + SUM_W'(digit) * SUM_W'(POW_F);
    assign frac_sum = SUM_W'(acc) + SUM_W'(digit) * SUM_W'(wtab[fds]);
    assign int_sat  = (int_sum > SUM_W'(CAP)) ? ACC_W'(CAP) : int_sum[ACC_W-1:0];
    assign frac_sat = (frac_sum > SUM_W'(CAP)) ? ACC_W'(CAP) : frac_sum[ACC_W-1:0];
    assign scaled   = CMP_W'(acc) * CMP_W'(vgfp_pkg::PROB_SCALE);
    assign thresh   = CMP_W'(min_prob) * CMP_W'(POW_F);

    always_comb begin
        fin_count = flags.count;
        if (flags.has_digit && (flags.count != vgfp_pkg::PROB_TRIPLE)) begin
            fin_count = flags.count + 2'd1;
        end
    end

    assign fin_any  = flags.any_ok | (flags.has_digit && (scaled >= thresh));
    assign fin_perr = flags.perr | !flags.has_digit
                    | (fin_count == vgfp_pkg::PROB_TRIPLE);

    always_comb begin
        acc_next   = acc;
        fds_next   = fds;
        flags_next = flags;
        if (do_finish || (do_char && !is_digit
                && !((ch == vgfp_pkg::CH_DOT) && !flags.in_frac))) begin
            acc_next             = '0;
            fds_next             = '0;
            flags_next.count     = fin_count;
            flags_next.any_ok    = fin_any;
            flags_next.perr      = fin_perr | (!do_finish && (ch != vgfp_pkg::CH_COMMA));
            flags_next.in_frac   = 1'b0;
            flags_next.has_digit = 1'b0;
        end else if (do_char) begin
            if (is_digit) begin
                flags_next.has_digit = 1'b1;
                if (flags.in_frac) begin
                    if (fds < FD_W'(FRAC_DIGITS)) begin
                        acc_next = frac_sat;
                        fds_next = fds + FD_W'(1);
                    end
                end else begin
                    acc_next = int_sat;
                end
            end else begin
                flags_next.in_frac = 1'b1;
            end
        end
    end

endmodule

// File: sv/vgfp_parser.sv
// Per-sample parser state: subfield counting, GT dosage and GP check, one byte a step.
// Depends on vgfp_pkg and vgfp_prob_step.
`timescale 1ns / 1ps

module vgfp_parser #(
    parameter int MAX_SUBFIELDS = vgfp_pkg::MAX_SUBFIELDS,
    parameter int FRAC_DIGITS   = vgfp_pkg::FRAC_DIGITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vgfp_pkg::cfg_t        cfg,
    input  logic                  step,
    input  logic [7:0]            ch,
    output vgfp_pkg::result_t     res
);

    localparam int ACC_W = vgfp_pkg::acc_width(FRAC_DIGITS);
    localparam int FD_W  = vgfp_pkg::fd_width(FRAC_DIGITS);
    localparam int SC_W  = $clog2(MAX_SUBFIELDS + 1);
    localparam int IDX_W = (SC_W > 4) ? SC_W : 4;

    logic [SC_W-1:0]       sc_reg, sc_next;
    logic [1:0]            cpos_reg, cpos_next;
    logic                  gt_seen_reg, gt_seen_next;
    logic [1:0]            dose_reg, dose_next;
    logic                  amiss_reg, amiss_next;
    logic                  tok_reg, tok_next;
    logic                  gp_seen_reg, gp_seen_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [FD_W-1:0]       fds_reg, fds_next;
    vgfp_pkg::prob_flags_t flags_reg, flags_next;

    logic [ACC_W-1:0]      pacc;
    logic [FD_W-1:0]       pfds;
    vgfp_pkg::prob_flags_t pflags;

    logic is_ws, is_colon, valid_idx, in_gt, in_gp, check_on, gp_active;
    logic do_char, do_finish, ok;

    assign is_ws = (ch == vgfp_pkg::CH_TAB) || (ch == vgfp_pkg::CH_SPACE)
                || (ch == vgfp_pkg::CH_CR)  || (ch == vgfp_pkg::CH_LF);
    assign is_colon  = (ch == vgfp_pkg::CH_COLON);
    assign valid_idx = (sc_reg < SC_W'(MAX_SUBFIELDS));
    assign in_gt     = valid_idx && (IDX_W'(sc_reg) == IDX_W'(cfg.gt_field));
    assign in_gp     = !in_gt && cfg.gp_present && valid_idx
                    && (IDX_W'(sc_reg) == IDX_W'(cfg.gp_field));
    assign check_on  = cfg.gp_present && (cfg.min_prob != '0);
    assign gp_active = in_gp && check_on && gp_seen_reg && !flags_reg.perr;
    assign do_finish = gp_active && (is_ws || is_colon);
    assign do_char   = !is_ws && !is_colon && in_gp && check_on && !flags_reg.perr;

    vgfp_prob_step #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_prob (
        .ch         (ch),
        .do_char    (do_char),
        .do_finish  (do_finish),
        .min_prob   (cfg.min_prob),
        .acc        (acc_reg),
        .fds        (fds_reg),
        .flags      (flags_reg),
        .acc_next   (pacc),
        .fds_next   (pfds),
        .flags_next (pflags)
    );

    assign ok = !(check_on && gp_seen_reg)
             || ((pflags.count == vgfp_pkg::PROB_TRIPLE) && pflags.any_ok);

    always_comb begin
        res.valid       = step && is_ws && tok_reg;
        res.low_quality = !ok;
        res.genotype    = (!ok || !gt_seen_reg || amiss_reg) ? vgfp_pkg::GENO_MISSING
                                                             : dose_reg;
    end

    always_comb begin
        sc_next      = sc_reg;
        cpos_next    = cpos_reg;
        gt_seen_next = gt_seen_reg;
        dose_next    = dose_reg;
        amiss_next   = amiss_reg;
        tok_next     = tok_reg;
        gp_seen_next = gp_seen_reg;
        acc_next     = pacc;
        fds_next     = pfds;
        flags_next   = pflags;
        if (is_ws) begin
            sc_next      = '0;
            cpos_next    = '0;
            gt_seen_next = 1'b0;
            dose_next    = '0;
            amiss_next   = 1'b0;
            tok_next     = 1'b0;
            gp_seen_next = 1'b0;
            acc_next     = '0;
            fds_next     = '0;
            flags_next   = '0;
        end else if (is_colon) begin
            tok_next             = 1'b1;
            acc_next             = '0;
            fds_next             = '0;
            flags_next.in_frac   = 1'b0;
            flags_next.has_digit = 1'b0;
            cpos_next            = '0;
            if (valid_idx) begin
                sc_next = sc_reg + SC_W'(1);
            end
        end else begin
            tok_next = 1'b1;
            if (in_gt) begin
                gt_seen_next = 1'b1;
                if ((cpos_reg == 2'd0) || (cpos_reg == 2'd2)) begin
                    if (ch == vgfp_pkg::CH_ONE) begin
                        if (dose_reg != 2'd2) begin
                            dose_next = dose_reg + 2'd1;
                        end
                    end else if (ch == vgfp_pkg::CH_DOT) begin
                        amiss_next = 1'b1;
                    end
                end
                if (cpos_reg != 2'd3) begin
                    cpos_next = cpos_reg + 2'd1;
                end
            end else if (in_gp) begin
                gp_seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_reg      <= '0;
            cpos_reg    <= '0;
            gt_seen_reg <= 1'b0;
            dose_reg    <= '0;
            amiss_reg   <= 1'b0;
            tok_reg     <= 1'b0;
            gp_seen_reg <= 1'b0;
            acc_reg     <= '0;
            fds_reg     <= '0;
            flags_reg   <= '0;
        end else if (step) begin
            sc_reg      <= sc_next;
            cpos_reg    <= cpos_next;
            gt_seen_reg <= gt_seen_next;
            dose_reg    <= dose_next;
            amiss_reg   <= amiss_next;
            tok_reg     <= tok_next;
            gp_seen_reg <= gp_seen_next;
            acc_reg     <= acc_next;
            fds_reg     <= fds_next;
            flags_reg   <= flags_next;
        end
    end

endmodule
